@@ hw/rtl/stack_bytecode_executor_defines.svh @@
// Assertion macros shared by the executor RTL.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define SBE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sbe_pkg.sv @@
// Package for the stack bytecode executor: opcodes, status codes,
// cell shift select and parameter defaults. No dependencies.
package sbe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned LOCAL_SLOTS_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  localparam logic [7:0] OP_POP      = 8'h02;
  localparam logic [7:0] OP_ADD      = 8'h03;
  localparam logic [7:0] OP_SUB      = 8'h04;
  localparam logic [7:0] OP_PRINT    = 8'h05;
  localparam logic [7:0] OP_STORE    = 8'h06;
  localparam logic [7:0] OP_LOAD     = 8'h07;
  localparam logic [7:0] OP_CONST_LO = 8'd101;
  localparam logic [7:0] OP_CONST_HI = 8'd105;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_BADARG    = 3'd2,
    ST_UNDER     = 3'd3,
    ST_OVER      = 3'd4,
    ST_UNWRITTEN = 3'd5
  } status_e;

  // what a stack cell loads on a clock edge
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT
  } cell_sel_e;

endpackage

@@ hw/rtl/sbe_req_if.sv @@
// Instruction channel: valid/ready plus opcode and slot argument.
// No dependencies.
interface sbe_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] req_type;
  logic [3:0] slot_index;
  logic       slot_valid;

  modport source (output valid, req_type, slot_index, slot_valid, input ready);
  modport sink   (input valid, req_type, slot_index, slot_valid, output ready);
endinterface

@@ hw/rtl/sbe_rsp_if.sv @@
// Result channel: valid/ready plus print value and status.
// Depends on sbe_pkg.
interface sbe_rsp_if;
  import sbe_pkg::*;
  logic               valid;
  logic               ready;
  logic               print_valid;
  logic signed [31:0] print_value;
  status_e            status;

  modport source (output valid, print_valid, print_value, status, input ready);
  modport sink   (input valid, print_valid, print_value, status, output ready);
endinterface

@@ hw/rtl/stack_bytecode_executor.sv @@
// Stack bytecode executor: operand stack as a row of shift cells, slots in RAM.
// The result is valid after the instruction transaction passes the request
// register with slot RAM read, then execute into the output register.
// Throughput: one instruction per cycle while the output is not stalled; cell row
// updates top and second entry in a single edge; slot RAM has a write-to-read bypass.
// Reset clears stack depth, slot-written bits and pipeline valids; no clear pass.
module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LOCAL_SLOTS = sbe_pkg::LOCAL_SLOTS_DEF,
  parameter int unsigned DATA_WIDTH  = sbe_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sbe_req_if.sink          req_i,
  sbe_rsp_if.source        rsp_o
);
  import sbe_pkg::*;
  `include "stack_bytecode_executor_defines.svh"

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

  // execute stage
  logic                  s1_valid_q;
  logic [7:0]            s1_op_q;
  logic                  s1_arg_ok_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  s1_fwd_q;
  logic [DATA_WIDTH-1:0] s1_fwd_data_q;

  logic [DW-1:0]          depth_q, depth_d;
  logic [LOCAL_SLOTS-1:0] slot_written_q;

  logic                  out_valid_q;
  logic                  out_pv_q;
  logic signed [31:0]    out_value_q;
  status_e               out_status_q;

  logic [DATA_WIDTH-1:0] cell_data [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] top, sec, top_in, ram_rdata, load_data, const_val;
  cell_sel_e             top_sel, rest_sel, top_sel_g, rest_sel_g;
  status_e               status;
  logic                  exec_pv, exec_store, depth_inc, depth_dec;
  logic                  out_free, fire, commit, slot_we, accept;
  logic                  full, empty, lt2, in_arg_ok;
  logic [AW-1:0]         in_addr;

  assign top       = cell_data[0];
  assign sec       = cell_data[1];
  assign full      = (depth_q == DW'(STACK_DEPTH));
  assign empty     = (depth_q == '0);
  assign lt2       = (depth_q < DW'(2));
  assign const_val = DATA_WIDTH'(s1_op_q - OP_CONST_LO);
  assign load_data = s1_fwd_q ? s1_fwd_data_q : ram_rdata;

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign fire         = s1_valid_q && out_free;
  assign req_i.ready  = !s1_valid_q || fire;
  assign accept       = req_i.valid && req_i.ready;

  assign in_arg_ok = req_i.slot_valid && ({5'd0, req_i.slot_index} < 9'(LOCAL_SLOTS));
  assign in_addr   = AW'(req_i.slot_index);

  // decode and check
  always_comb begin
    status     = ST_OK;
    top_sel    = SEL_HOLD;
    rest_sel   = SEL_HOLD;
    top_in     = const_val;
    exec_pv    = 1'b0;
    exec_store = 1'b0;
    depth_inc  = 1'b0;
    depth_dec  = 1'b0;
    case (s1_op_q)
      OP_POP, OP_PRINT: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          top_sel   = SEL_NEXT;
          rest_sel  = SEL_NEXT;
          depth_dec = 1'b1;
          exec_pv   = (s1_op_q == OP_PRINT);
        end
      end
      OP_ADD, OP_SUB: begin
        top_in = (s1_op_q == OP_ADD) ? (top + sec) : (top - sec);
        if (lt2) begin
          status = ST_UNDER;
        end else begin
          top_sel   = SEL_PREV;
          rest_sel  = SEL_NEXT;
          depth_dec = 1'b1;
        end
      end
      OP_STORE: begin
        if (!s1_arg_ok_q) begin
          status = ST_BADARG;
        end else if (empty) begin
          status = ST_UNDER;
        end else begin
          top_sel    = SEL_NEXT;
          rest_sel   = SEL_NEXT;
          depth_dec  = 1'b1;
          exec_store = 1'b1;
        end
      end
      OP_LOAD: begin
        top_in = load_data;
        if (!s1_arg_ok_q) begin
          status = ST_BADARG;
        end else if (!slot_written_q[s1_addr_q]) begin
          status = ST_UNWRITTEN;
        end else if (full) begin
          status = ST_OVER;
        end else begin
          top_sel   = SEL_PREV;
          rest_sel  = SEL_PREV;
          depth_inc = 1'b1;
        end
      end
      default: begin
        if (s1_op_q >= OP_CONST_LO && s1_op_q <= OP_CONST_HI) begin
          if (full) begin
            status = ST_OVER;
          end else begin
            top_sel   = SEL_PREV;
            rest_sel  = SEL_PREV;
            depth_inc = 1'b1;
          end
        end else begin
          status = ST_UNKNOWN;
        end
      end
    endcase
  end

  assign commit     = fire && (status == ST_OK);
  assign slot_we    = commit && exec_store;
  assign top_sel_g  = commit ? top_sel  : SEL_HOLD;
  assign rest_sel_g = commit ? rest_sel : SEL_HOLD;

  always_comb begin
    depth_d = depth_q;
    if (commit && depth_inc) begin
      depth_d = depth_q + DW'(1);
    end else if (commit && depth_dec) begin
      depth_d = depth_q - DW'(1);
    end
  end

  // operand stack cells, index 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    sbe_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .sel_i  ((i == 0) ? top_sel_g : rest_sel_g),
      .prev_i ((i == 0) ? top_in : cell_data[(i == 0) ? 0 : i - 1]),
      .next_i (cell_data[(i == STACK_DEPTH - 1) ? i : i + 1]),
      .data_o (cell_data[i])
    );
  end

  sbe_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LOCAL_SLOTS),
    .AW    (AW)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (s1_addr_q),
    .wdata_i (top),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      depth_q        <= '0;
      slot_written_q <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      out_valid_q <= fire || (out_valid_q && !rsp_o.ready);
      depth_q     <= depth_d;
      if (slot_we) begin
        slot_written_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= req_i.req_type;
      s1_arg_ok_q <= in_arg_ok;
      s1_addr_q   <= in_addr;
      // RAM reads old data when a store to the same slot commits this edge
      s1_fwd_q      <= slot_we && (s1_addr_q == in_addr);
      s1_fwd_data_q <= top;
    end
    if (fire) begin
      out_pv_q     <= exec_pv;
      out_value_q  <= exec_pv ? 32'($signed(top)) : '0;
      out_status_q <= status;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.print_valid = out_pv_q;
  assign rsp_o.print_value = out_value_q;
  assign rsp_o.status      = out_status_q;

  `SBE_ASSERT_IMPL(a_depth_bound, 1'b1, depth_q <= DW'(STACK_DEPTH), "stack depth out of range")
  `SBE_ASSERT_IMPL(a_print_ok, out_valid_q && out_pv_q, out_status_q == ST_OK, "print with fault")
  `SBE_ASSERT_NEXT(a_fault_no_change, fire && (status != ST_OK), $stable(depth_q),
                   "faulting transaction changed depth")
  `SBE_ASSERT_IMPL(a_stall_no_exec, s1_valid_q && out_valid_q && !rsp_o.ready, !commit,
                   "execute while output stalled")

endmodule

@@ hw/rtl/sbe_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-old).
// No dependencies.
module sbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sbe_cell.sv @@
// One operand stack entry; shifts toward or away from the top.
// Depends on sbe_pkg.
module sbe_cell #(
  parameter int unsigned DATA_WIDTH = sbe_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  sbe_pkg::cell_sel_e    sel_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import sbe_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (sel_i)
      SEL_PREV: data_d = prev_i;
      SEL_NEXT: data_d = next_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
